FILE: design/rad_pkg.sv
// ----------------------------------------------------------------------------
// rad_pkg: shared types and constants of the region address decoder
// Widths, operation and status codes, and the structs that pass between
// the slot table, the decision logic and the top level.
// ----------------------------------------------------------------------------
package rad_pkg;

  localparam int MaxRegions = 16;
  localparam int IdxW       = 4;
  localparam int AddrW      = 32;
  localparam int EndW       = AddrW + 1;
  localparam int PermW      = 3;
  localparam int StatW      = 3;
  localparam int OpW        = 2;

  localparam logic [EndW-1:0] AddrLimit = {1'b1, {AddrW{1'b0}}};

  localparam logic [OpW-1:0] OpAccess  = 2'd0;
  localparam logic [OpW-1:0] OpMapRam  = 2'd1;
  localparam logic [OpW-1:0] OpMapMmio = 2'd2;

  localparam logic [StatW-1:0] StOk          = 3'd0;
  localparam logic [StatW-1:0] StInvalid     = 3'd1;
  localparam logic [StatW-1:0] StOutOfBounds = 3'd2;
  localparam logic [StatW-1:0] StOverlap     = 3'd3;
  localparam logic [StatW-1:0] StViolation   = 3'd4;
  localparam logic [StatW-1:0] StUnmapped    = 3'd5;
  localparam logic [StatW-1:0] StTableFull   = 3'd6;
  localparam logic [StatW-1:0] StUnsupported = 3'd7;

  localparam int PermExec = 2;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] length;
    logic [PermW-1:0] perms;
    logic [AddrW-1:0] phys_offset;
  } req_t;

  // delta is added to a guest address to give the translated offset
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] base;
    logic [EndW-1:0]  last;
    logic [PermW-1:0] perms;
    logic             mmio;
    logic [AddrW-1:0] delta;
  } slot_wr_t;

  typedef struct packed {
    logic [MaxRegions-1:0] valid;
    logic                  any_hit;
    logic [IdxW-1:0]       hit_idx;
    logic [EndW-1:0]       hit_last;
    logic [PermW-1:0]      hit_perms;
    logic                  hit_mmio;
    logic [AddrW-1:0]      hit_delta;
    logic                  any_overlap;
    logic                  has_free;
    logic [IdxW-1:0]       free_idx;
  } table_info_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  idx;
    logic             mmio;
    logic [AddrW-1:0] offset;
  } result_t;

endpackage

FILE: design/rad_slot_table.sv
// ----------------------------------------------------------------------------
// rad_slot_table: region slot storage with parallel range compare
// Holds the region entries, compares every valid slot against the query
// range, and returns the lowest hit, the lowest free slot and overlap.
// ----------------------------------------------------------------------------
module rad_slot_table
  import rad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_wr_t         wr_i,
  input  logic [AddrW-1:0] q_addr_i,
  input  logic [EndW-1:0]  q_end_i,
  output table_info_t      info_o
);

  logic [MaxRegions-1:0] valid_q;
  logic [AddrW-1:0]      base_q  [MaxRegions];
  logic [EndW-1:0]       last_q  [MaxRegions];
  logic [PermW-1:0]      perms_q [MaxRegions];
  logic                  mmio_q  [MaxRegions];
  logic [AddrW-1:0]      delta_q [MaxRegions];

  logic [MaxRegions-1:0] hit;
  logic [MaxRegions-1:0] ovl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      base_q[wr_i.idx]  <= wr_i.base;
      last_q[wr_i.idx]  <= wr_i.last;
      perms_q[wr_i.idx] <= wr_i.perms;
      mmio_q[wr_i.idx]  <= wr_i.mmio;
      delta_q[wr_i.idx] <= wr_i.delta;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxRegions; i++) begin
      hit[i] = valid_q[i] && (q_addr_i >= base_q[i]) && ({1'b0, q_addr_i} < last_q[i]);
      ovl[i] = valid_q[i] && ({1'b0, q_addr_i} < last_q[i]) && ({1'b0, base_q[i]} < q_end_i);
    end
  end

  always_comb begin
    info_o             = '0;
    info_o.valid       = valid_q;
    info_o.any_hit     = |hit;
    info_o.any_overlap = |ovl;
    info_o.has_free    = ~&valid_q;
    for (int i = MaxRegions - 1; i >= 0; i--) begin
      if (hit[i]) begin
        info_o.hit_idx   = IdxW'(i);
        info_o.hit_last  = last_q[i];
        info_o.hit_perms = perms_q[i];
        info_o.hit_mmio  = mmio_q[i];
        info_o.hit_delta = delta_q[i];
      end
      if (!valid_q[i]) begin
        info_o.free_idx = IdxW'(i);
      end
    end
  end

endmodule

FILE: design/rad_decide.sv
// ----------------------------------------------------------------------------
// rad_decide: operation checks and result selection
// Applies the map and access checks in order, builds the result and the
// slot write for a successful map.
// ----------------------------------------------------------------------------
module rad_decide
  import rad_pkg::*;
(
  input  req_t             req_i,
  input  logic [EndW-1:0]  req_end_i,
  input  logic [EndW-1:0]  ram_size_i,
  input  table_info_t      info_i,
  output result_t          res_o,
  output slot_wr_t         wr_o
);

  logic            is_mmio_map;
  logic [EndW-1:0] ram_end;

  assign is_mmio_map = (req_i.operation == OpMapMmio);
  assign ram_end     = {1'b0, req_i.phys_offset} + {1'b0, req_i.length};

  always_comb begin
    res_o        = '0;
    res_o.status = StInvalid;
    wr_o         = '0;
    wr_o.idx     = info_i.free_idx;
    wr_o.base    = req_i.address;
    wr_o.last    = req_end_i;
    wr_o.perms   = req_i.perms;
    wr_o.mmio    = is_mmio_map;
    wr_o.delta   = is_mmio_map ? (AddrW'(0) - req_i.address)
                               : (req_i.phys_offset - req_i.address);
    case (req_i.operation)
      OpAccess: begin
        if (req_i.length == '0) begin
          res_o.status = StInvalid;
        end else if (req_end_i > AddrLimit) begin
          res_o.status = StOutOfBounds;
        end else if (!info_i.any_hit) begin
          res_o.status = StUnmapped;
        end else begin
          res_o.idx  = info_i.hit_idx;
          res_o.mmio = info_i.hit_mmio;
          if (req_end_i > info_i.hit_last) begin
            res_o.status = StOutOfBounds;
          end else if ((info_i.hit_perms & req_i.perms) != req_i.perms) begin
            res_o.status = StViolation;
          end else if (info_i.hit_mmio && req_i.perms[PermExec]) begin
            res_o.status = StUnsupported;
          end else begin
            res_o.status = StOk;
            res_o.offset = req_i.address + info_i.hit_delta;
          end
        end
      end
      OpMapRam, OpMapMmio: begin
        if (req_i.length == '0) begin
          res_o.status = StInvalid;
        end else if (req_end_i > AddrLimit) begin
          res_o.status = StOutOfBounds;
        end else if (!is_mmio_map && (ram_end > ram_size_i)) begin
          res_o.status = StOutOfBounds;
        end else if (info_i.any_overlap) begin
          res_o.status = StOverlap;
        end else if (!info_i.has_free) begin
          res_o.status = StTableFull;
        end else begin
          res_o.status = StOk;
          res_o.idx    = info_i.free_idx;
          res_o.mmio   = is_mmio_map;
          wr_o.en      = 1'b1;
        end
      end
      default: begin
        res_o.status = StInvalid;
      end
    endcase
  end

endmodule

FILE: design/region_address_decoder_mpu.sv
// ----------------------------------------------------------------------------
// region_address_decoder_mpu: guest region decoder with protection checks
// The request is held in the input register and the decision in the result register.
// Throughput: one operation per cycle; busy_o is never raised.
// A map updates the slot table in time for the very next operation.
// The one pass from input register to result register sets the rate.
// Reset clears the slot table valid bits, ram_size and both valid flags.
// ----------------------------------------------------------------------------
module region_address_decoder_mpu
  import rad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OpW-1:0]    operation_i,
  input  logic [AddrW-1:0]  address_i,
  input  logic [AddrW-1:0]  length_i,
  input  logic [PermW-1:0]  perms_i,
  input  logic [AddrW-1:0]  phys_offset_i,
  input  logic              cfg_we_i,
  input  logic [EndW-1:0]   cfg_wdata_i,
  output logic              result_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [IdxW-1:0]   region_index_o,
  output logic              region_is_mmio_o,
  output logic [AddrW-1:0]  target_offset_o
);

  logic            in_valid_q;
  req_t            req_q;
  logic [EndW-1:0] ram_size_q;
  logic            res_valid_q;
  result_t         res_q;

  logic [EndW-1:0] req_end;
  table_info_t     info;
  result_t         res_d;
  slot_wr_t        wr_raw;
  slot_wr_t        wr;

  assign busy_o  = 1'b0;
  assign req_end = {1'b0, req_q.address} + {1'b0, req_q.length};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      ram_size_q  <= '0;
    end else begin
      in_valid_q  <= start_i && !busy_o;
      res_valid_q <= in_valid_q;
      if (cfg_we_i) begin
        ram_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q.operation   <= operation_i;
      req_q.address     <= address_i;
      req_q.length      <= length_i;
      req_q.perms       <= perms_i;
      req_q.phys_offset <= phys_offset_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  rad_slot_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .q_addr_i (req_q.address),
    .q_end_i  (req_end),
    .info_o   (info)
  );

  rad_decide u_decide (
    .req_i      (req_q),
    .req_end_i  (req_end),
    .ram_size_i (ram_size_q),
    .info_i     (info),
    .res_o      (res_d),
    .wr_o       (wr_raw)
  );

  always_comb begin
    wr    = wr_raw;
    wr.en = wr_raw.en && in_valid_q;
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_q.status;
  assign region_index_o   = res_q.idx;
  assign region_is_mmio_o = res_q.mmio;
  assign target_offset_o  = res_q.offset;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("result strobe missing after start transfer");

  a_no_offset_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != StOk) |-> (target_offset_o == '0))
    else $error("offset set on a failed operation");

  a_map_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> ($countones(info.valid) == $past($countones(info.valid)) + 1))
    else $error("successful map did not occupy exactly one slot");

  a_write_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> !info.valid[wr.idx])
    else $error("map wrote an occupied slot");

endmodule

FILE: tb/region_address_decoder_mpu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_address_decoder_mpu_test: self-checking bench for the region decoder
// Maps RAM and MMIO regions and resolves accesses against them. Both are
// checked against a cycle-free model of the slot table. A directed part covers
// every status code but table full, and the table edges. Random batches
// follow, ram_size changed before every fourth one while the block is drained.
// Starts come with random idle bursts, and the last batches run back to back.
// ----------------------------------------------------------------------------
module region_address_decoder_mpu_test;
  import rad_pkg::*;

  localparam logic [OpW-1:0] OpReserved = 2'd3;
  localparam int CycleLimit = 100000;
  localparam int NumBatches = 22;
  localparam int BatchItems = 50;
  localparam longint unsigned Span4G = 64'h1_0000_0000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [OpW-1:0]    operation_i = OpAccess;
  logic [AddrW-1:0]  address_i   = '0;
  logic [AddrW-1:0]  length_i    = '0;
  logic [PermW-1:0]  perms_i     = '0;
  logic [AddrW-1:0]  phys_offset_i = '0;
  logic              cfg_we_i    = 1'b0;
  logic [EndW-1:0]   cfg_wdata_i = '0;
  logic              busy_o;
  logic              result_valid_o;
  logic [StatW-1:0]  status_o;
  logic [IdxW-1:0]   region_index_o;
  logic              region_is_mmio_o;
  logic [AddrW-1:0]  target_offset_o;

  region_address_decoder_mpu u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .perms_i          (perms_i),
    .phys_offset_i    (phys_offset_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .region_index_o   (region_index_o),
    .region_is_mmio_o (region_is_mmio_o),
    .target_offset_o  (target_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the slot table and ram_size
  bit             slot_used  [MaxRegions];
  bit [AddrW-1:0] slot_lo    [MaxRegions];
  bit [AddrW-1:0] slot_len   [MaxRegions];
  bit [PermW-1:0] slot_grant [MaxRegions];
  bit             slot_io    [MaxRegions];
  bit [AddrW-1:0] slot_phys  [MaxRegions];
  bit [EndW-1:0]  ram_limit = '0;

  req_t    pending_reqs[$];
  result_t outcomes_due[$];
  int      err_count = 0;
  int      gap_left  = 0;
  bit      idle_on   = 1'b1;

  function automatic result_t decode_request(input req_t r);
    result_t res;
    longint unsigned a, n, lo, hi;
    int i, free_at;
    bit hit, clash, is_io;
    res = '0;
    a = 64'(r.address);
    n = 64'(r.length);
    is_io = (r.operation == OpMapMmio);
    hit = 1'b0;
    clash = 1'b0;
    free_at = -1;
    case (r.operation)
      OpAccess: begin
        if (n == 0) res.status = StInvalid;
        else if (a + n > Span4G) res.status = StOutOfBounds;
        else begin
          res.status = StUnmapped;
          for (i = 0; i < MaxRegions; i++) begin
            lo = 64'(slot_lo[i]);
            hi = lo + 64'(slot_len[i]);
            if (!hit && slot_used[i] && a >= lo && a < hi) begin
              hit = 1'b1;
              res.idx = i[IdxW-1:0];
              res.mmio = slot_io[i];
              if (a + n > hi) res.status = StOutOfBounds;
              else if ((slot_grant[i] & r.perms) != r.perms) res.status = StViolation;
              else if (slot_io[i] && r.perms[PermExec]) res.status = StUnsupported;
              else begin
                res.status = StOk;
                res.offset = slot_io[i] ? AddrW'(a - lo)
                                        : AddrW'(64'(slot_phys[i]) + (a - lo));
              end
            end
          end
        end
      end
      OpMapRam, OpMapMmio: begin
        if (n == 0) res.status = StInvalid;
        else if (a + n > Span4G) res.status = StOutOfBounds;
        else if (!is_io && (64'(r.phys_offset) + n > 64'(ram_limit)))
          res.status = StOutOfBounds;
        else begin
          for (i = 0; i < MaxRegions; i++) begin
            if (slot_used[i]) begin
              lo = 64'(slot_lo[i]);
              hi = lo + 64'(slot_len[i]);
              if (a < hi && lo < a + n) clash = 1'b1;
            end else if (free_at < 0) begin
              free_at = i;
            end
          end
          if (clash) res.status = StOverlap;
          else if (free_at < 0) res.status = StTableFull;
          else begin
            slot_used[free_at]  = 1'b1;
            slot_lo[free_at]    = r.address;
            slot_len[free_at]   = r.length;
            slot_grant[free_at] = r.perms;
            slot_io[free_at]    = is_io;
            slot_phys[free_at]  = is_io ? '0 : r.phys_offset;
            res.status = StOk;
            res.idx = free_at[IdxW-1:0];
            res.mmio = is_io;
          end
        end
      end
      default: res.status = StInvalid;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin : drive_requests
    req_t taken, nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (cfg_we_i) ram_limit = cfg_wdata_i;
      if (start_i && !busy_o) begin
        taken.operation   = operation_i;
        taken.address     = address_i;
        taken.length      = length_i;
        taken.perms       = perms_i;
        taken.phys_offset = phys_offset_i;
        outcomes_due.insert(outcomes_due.size(), decode_request(taken));
      end
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          start_i <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          if (idle_on && $urandom_range(0, 3) == 0) begin
            start_i <= 1'b0;
            gap_left = $urandom_range(0, 3);
          end else begin
            nxt = pending_reqs.pop_front();
            operation_i   <= nxt.operation;
            address_i     <= nxt.address;
            length_i      <= nxt.length;
            perms_i       <= nxt.perms;
            phys_offset_i <= nxt.phys_offset;
            start_i       <= 1'b1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t got, want;
    if (rst_ni && result_valid_o) begin
      got.status = status_o;
      got.idx    = region_index_o;
      got.mmio   = region_is_mmio_o;
      got.offset = target_offset_o;
      if (outcomes_due.size() == 0) begin
        note_error($sformatf("unexpected result status=%0d idx=%0d mmio=%0b off=%h",
                             got.status, got.idx, got.mmio, got.offset));
      end else begin
        want = outcomes_due.pop_front();
        if (got.status !== want.status || got.idx !== want.idx ||
            got.mmio !== want.mmio || got.offset !== want.offset)
          note_error($sformatf({"mismatch exp status=%0d idx=%0d mmio=%0b off=%h",
                                " got status=%0d idx=%0d mmio=%0b off=%h"},
                               want.status, want.idx, want.mmio, want.offset,
                               got.status, got.idx, got.mmio, got.offset));
      end
    end
  end

  task automatic push_item(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                           input logic [AddrW-1:0] len, input logic [PermW-1:0] perms,
                           input logic [AddrW-1:0] roff);
    req_t r;
    r.operation   = op;
    r.address     = addr;
    r.length      = len;
    r.perms       = perms;
    r.phys_offset = roff;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_random();
    int used_ids[$];
    int pick, s;
    longint unsigned sz, base, lo, len, rel, n, room;
    req_t r;
    for (s = 0; s < MaxRegions; s++) if (slot_used[s]) used_ids.insert(used_ids.size(), s);
    r = '0;
    r.perms = PermW'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.operation = $urandom_range(0, 1) ? OpMapRam : OpMapMmio;
      case ($urandom_range(0, 3))
        0, 1: sz = 64'($urandom_range(1, 4096));
        2: sz = 64'($urandom_range(1, 1 << 20));
        default: sz = 64'($urandom);
      endcase
      base = 64'($urandom) % (Span4G - sz + 1);
      if (used_ids.size() > 0) begin
        s = used_ids[$urandom_range(0, used_ids.size() - 1)];
        case ($urandom_range(0, 3))
          0: base = 64'(slot_lo[s]) + 64'(slot_len[s]);
          1: base = 64'(slot_lo[s]) + 64'($urandom) % 64'(slot_len[s]);
          2: base = 64'($urandom);
          default: ;
        endcase
      end
      room = (64'(ram_limit) > sz) ? 64'(ram_limit) - sz : 64'd0;
      if ($urandom_range(0, 7) == 0) r.phys_offset = $urandom;
      else r.phys_offset = AddrW'(64'($urandom) % (room + 1));
      r.address = AddrW'(base);
      r.length  = AddrW'(sz);
    end else if (pick < 85 && used_ids.size() > 0) begin
      s = used_ids[$urandom_range(0, used_ids.size() - 1)];
      lo = 64'(slot_lo[s]);
      len = 64'(slot_len[s]);
      case ($urandom_range(0, 3))
        0: rel = 0;
        1: rel = len - 1;
        2: rel = len;
        default: rel = 64'($urandom) % len;
      endcase
      n = len - rel;
      case ($urandom_range(0, 5))
        0: ;
        1: n = n + 1;
        2: n = 0;
        3: n = 64'($urandom);
        default: n = 64'($urandom_range(1, 8));
      endcase
      r.operation = OpAccess;
      r.address   = AddrW'(lo + rel);
      r.length    = AddrW'(n);
    end else begin
      r.operation   = OpW'($urandom_range(0, 3));
      r.address     = $urandom;
      r.length      = $urandom;
      r.phys_offset = $urandom;
    end
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // sampled at the falling edge, where the driver and the checker have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start_i || outcomes_due.size() != 0);
  endtask

  task automatic set_ram_size(input logic [EndW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : run_limit
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("region_address_decoder_mpu_test: errors");
    $finish;
  end

  initial begin : stimulus
    int b, k;
    logic [EndW-1:0] ram_choice;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ram_size still at reset: RAM maps cannot fit
    push_item(OpAccess,   32'h0000_1000, 32'd4,         3'b001, '0);
    push_item(OpAccess,   32'h0000_1000, 32'd0,         3'b001, '0);
    push_item(OpAccess,   32'hFFFF_FFFF, 32'd2,         3'b001, '0);
    push_item(OpReserved, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 32'hFFFF_FFFF);
    push_item(OpMapRam,   32'h0000_1000, 32'h100,       3'b011, '0);
    push_item(OpMapMmio,  32'h0000_1000, 32'd0,         3'b011, '0);
    push_item(OpMapMmio,  32'hFFFF_F001, 32'h1000,      3'b111, '0);
    push_item(OpMapMmio,  32'hFFFF_F000, 32'h1000,      3'b111, '0);
    push_item(OpAccess,   32'hFFFF_FFFF, 32'd1,         3'b111, '0);
    push_item(OpAccess,   32'hFFFF_F010, 32'd4,         3'b011, '0);

    set_ram_size(EndW'(Span4G));
    push_item(OpMapRam,   32'h0000_1000, 32'h1000,      3'b011, 32'hFFFF_F800);
    push_item(OpMapRam,   32'h0000_1000, 32'h1000,      3'b011, 32'hFFFF_F000);
    push_item(OpAccess,   32'h0000_1800, 32'h10,        3'b001, '0);
    push_item(OpAccess,   32'h0000_1FFF, 32'd2,         3'b001, '0);
    push_item(OpAccess,   32'h0000_1000, 32'd4,         3'b100, '0);
    push_item(OpAccess,   32'h0000_1000, 32'h1000,      3'b000, '0);
    push_item(OpMapMmio,  32'h0000_1800, 32'h10,        3'b011, '0);
    push_item(OpMapRam,   32'h0000_0000, 32'h1000,      3'b101, '0);
    push_item(OpMapMmio,  32'h0000_2000, 32'h100,       3'b010, '0);
    push_item(OpAccess,   32'h0000_2000, 32'h100,       3'b010, '0);
    push_item(OpAccess,   32'h0000_2100, 32'd1,         3'b001, '0);
    push_item(OpAccess,   32'h0000_0000, 32'hFFFF_FFFF, 3'b001, '0);
    push_item(OpMapMmio,  32'h0000_0000, 32'hFFFF_FFFF, 3'b001, '0);

    for (b = 0; b < NumBatches; b++) begin
      if (b % 4 == 0) begin
        case (b / 4)
          0: ram_choice = EndW'(Span4G);
          1: ram_choice = {1'b0, 32'($urandom)};
          2: ram_choice = '0;
          3: ram_choice = {1'b0, 32'hFFFF_FFFF};
          4: ram_choice = EndW'(1 << 20);
          default: ram_choice = EndW'(Span4G);
        endcase
        set_ram_size(ram_choice);
      end else begin
        wait_drained();
      end
      idle_on = (b < NumBatches - 3) && ($urandom_range(0, 2) != 0);
      for (k = 0; k < BatchItems; k++) push_random();
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (err_count == 0 && outcomes_due.size() == 0)
      $display("region_address_decoder_mpu_test: clean");
    else
      $display("region_address_decoder_mpu_test: errors");
    $finish;
  end

endmodule
